// ----- src/ted_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Text encoding detector package
// Result codes, byte order mark and UTF-8 tag constants used by the detector.
// ----------------------------------------------------------------------------
package ted_pkg;

  localparam int unsigned ByteW = 8;
  localparam int unsigned EncW  = 3;

  typedef enum logic [EncW-1:0] {
    ENC_UNKNOWN  = 3'd0,
    ENC_UTF16_LE = 3'd1,
    ENC_UTF16_BE = 3'd2,
    ENC_UTF8_BOM = 3'd3,
    ENC_UTF8     = 3'd4,
    ENC_ANSI     = 3'd5
  } enc_e;

  localparam logic [ByteW-1:0] BomEf = 8'hEF;
  localparam logic [ByteW-1:0] BomBb = 8'hBB;
  localparam logic [ByteW-1:0] BomBf = 8'hBF;
  localparam logic [ByteW-1:0] BomFe = 8'hFE;
  localparam logic [ByteW-1:0] BomFf = 8'hFF;

  localparam logic [1:0] ContTag  = 2'b10;
  localparam logic [2:0] Lead2Tag = 3'b110;
  localparam logic [3:0] Lead3Tag = 4'b1110;
  localparam logic [4:0] Lead4Tag = 5'b11110;

endpackage

// ----- src/ted_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Text encoding detector channels
// Valid/ready channels for incoming bytes and outgoing classifications.
// ----------------------------------------------------------------------------
interface ted_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] byte_value;
  logic       last_byte;

  modport source (output valid, output byte_value, output last_byte, input ready);
  modport sink   (input valid, input byte_value, input last_byte, output ready);
endinterface

interface ted_out_if;
  logic       valid;
  logic       ready;
  logic [2:0] encoding;

  modport source (output valid, output encoding, input ready);
  modport sink   (input valid, input encoding, output ready);
endinterface

// ----- src/text_encoding_detector.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Text encoding detector
// Classifies a byte buffer by byte order mark and UTF-8 structure.
// ----------------------------------------------------------------------------
// One byte is taken per item, one item per clock unless a closing byte waits
// on a pending result. Each byte passes an input register, then combinational
// compares against the running buffer state (first two bytes, continuation
// bytes owed, fail and high-bit flags). The item flagged as last yields one
// classification, registered from the input into the result register. While
// a result waits, other bytes keep flowing; only a closing byte holds in the
// input register until the result is taken. State resets after each result.
module text_encoding_detector (
  input  logic             clk_i,
  input  logic             rst_ni,
  ted_in_if.sink           in_i,
  ted_out_if.source        out_o
);
  import ted_pkg::*;

  logic             in_valid_q;
  logic [ByteW-1:0] byte_q;
  logic             last_q;

  logic [1:0]       seen_q, seen_d;
  logic [ByteW-1:0] first_q, first_d;
  logic [ByteW-1:0] second_q, second_d;
  logic [1:0]       owed_q, owed_d;
  logic             fail_q, fail_d;
  logic             high_q, high_d;

  logic             out_valid_q, out_valid_d;
  enc_e             enc_q, enc_d;

  logic             proc;
  logic             emit;

  assign proc      = in_valid_q && (!last_q || !out_valid_q || out_o.ready);
  assign emit      = proc && last_q;
  assign in_i.ready = !in_valid_q || proc;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_i.ready) begin
      in_valid_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.ready && in_i.valid) begin
      byte_q <= in_i.byte_value;
      last_q <= in_i.last_byte;
    end
  end

  always_comb begin
    seen_d   = seen_q;
    first_d  = first_q;
    second_d = second_q;
    owed_d   = owed_q;
    fail_d   = fail_q;
    high_d   = high_q;
    enc_d    = enc_q;

    unique case (seen_q)
      2'd0: first_d = byte_q;
      2'd1: second_d = byte_q;
      2'd2: begin
        if (first_q == BomEf && second_q == BomBb && byte_q != BomBf) begin
          second_d = '0;
        end
      end
      default: ;
    endcase
    if (seen_q != 2'd3) begin
      seen_d = seen_q + 2'd1;
    end

    if (!fail_q) begin
      if (owed_q != 2'd0) begin
        if (byte_q[7:6] != ContTag) begin
          fail_d = 1'b1;
        end else begin
          owed_d = owed_q - 2'd1;
        end
      end else if (byte_q[7]) begin
        high_d = 1'b1;
        if (byte_q[7:5] == Lead2Tag) begin
          owed_d = 2'd1;
        end else if (byte_q[7:4] == Lead3Tag) begin
          owed_d = 2'd2;
        end else if (byte_q[7:3] == Lead4Tag) begin
          owed_d = 2'd3;
        end else begin
          fail_d = 1'b1;
        end
      end
    end

    if (seen_d != 2'd3) begin
      enc_d = ENC_UNKNOWN;
    end else if (first_d == BomFf && second_d == BomFe) begin
      enc_d = ENC_UTF16_LE;
    end else if (first_d == BomFe && second_d == BomFf) begin
      enc_d = ENC_UTF16_BE;
    end else if (first_d == BomEf && second_d == BomBb) begin
      enc_d = ENC_UTF8_BOM;
    end else if (fail_d || owed_d != 2'd0 || !high_d) begin
      enc_d = ENC_ANSI;
    end else begin
      enc_d = ENC_UTF8;
    end

    if (last_q) begin
      seen_d   = '0;
      first_d  = '0;
      second_d = '0;
      owed_d   = '0;
      fail_d   = 1'b0;
      high_d   = 1'b0;
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (emit) begin
      out_valid_d = 1'b1;
    end else if (out_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seen_q      <= '0;
      first_q     <= '0;
      second_q    <= '0;
      owed_q      <= '0;
      fail_q      <= 1'b0;
      high_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      if (proc) begin
        seen_q   <= seen_d;
        first_q  <= first_d;
        second_q <= second_d;
        owed_q   <= owed_d;
        fail_q   <= fail_d;
        high_q   <= high_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      enc_q <= enc_d;
    end
  end

  assign out_o.valid    = out_valid_q;
  assign out_o.encoding = enc_q;

  // buffer state is cleared once its result is taken into the result register
  a_clear_after_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    emit |=> (seen_q == 2'd0 && owed_q == 2'd0 && !fail_q && !high_q))
    else $error("buffer state not cleared after result");

  // owed continuations only follow a high lead byte
  a_owed_needs_lead: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (owed_q != 2'd0) |-> high_q)
    else $error("continuations owed without a lead byte");

  a_fail_needs_high: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fail_q |-> high_q)
    else $error("sequence failure without a high byte");

  // a result is never overwritten while waiting
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_o.ready) |-> !emit)
    else $error("pending result overwritten");

endmodule
